### hw/rtl/tct_pkg.sv
// ----------------------------------------------------------------------------
// tct_pkg
// Shared constants and types for the texture completeness tracker.
// ----------------------------------------------------------------------------
`default_nettype none
package tct_pkg;
  localparam int MAX_LEVELS = 16;
  localparam int FACES      = 6;
  localparam int LVL_W      = $clog2(MAX_LEVELS);
  localparam int FACE_W     = 3;
  localparam int DEPTH      = FACES * MAX_LEVELS;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = LVL_W + 1;

  localparam logic [1:0] REQ_SET   = 2'd0;
  localparam logic [1:0] REQ_GEN   = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;
  localparam logic [1:0] REQ_RSVD  = 2'd3;

  localparam logic [1:0] TGT_2D   = 2'd1;
  localparam logic [1:0] TGT_CUBE = 2'd2;
  localparam logic [1:0] TGT_RSVD = 2'd3;

  localparam logic [2:0] CFG_TARGET = 3'd0;
  localparam logic [2:0] CFG_LEVELS = 3'd1;
  localparam logic [2:0] CFG_MINF   = 3'd2;
  localparam logic [2:0] CFG_WRAPS  = 3'd3;
  localparam logic [2:0] CFG_WRAPT  = 3'd4;

  localparam logic [2:0] FILT_NEAREST = 3'd0;
  localparam logic [2:0] FILT_LINEAR  = 3'd1;
  localparam logic [1:0] WRAP_CLAMP   = 2'd1;

  typedef struct packed {
    logic [15:0] fmt;
    logic [15:0] typ;
    logic [14:0] w;
    logic [14:0] h;
  } desc_t;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [FACE_W-1:0] f,
                                                input logic [LVL_W-1:0] l);
    addr_of = ADDR_W'(f) * ADDR_W'(MAX_LEVELS) + ADDR_W'(l);
  endfunction

  function automatic logic [14:0] half_side(input logic [14:0] v);
    half_side = (v > 15'd1) ? (v >> 1) : 15'd1;
  endfunction
endpackage
`default_nettype wire

### hw/rtl/texture_completeness_tracker.sv
// ----------------------------------------------------------------------------
// texture_completeness_tracker
// Mip level descriptor table with completeness and black-texture flags.
// ----------------------------------------------------------------------------
// One request at a time; busy is high while a request is in work. The table
// sits in a 96-entry single-port RAM (one access per cycle, registered read,
// so each descriptor read has an address phase and a data phase). The result
// strobe ends every request; for a set it follows the recheck sweep, which
// reads level 0 and the needed chain levels of every face (up to 90 reads). A
// generate adds a base check of every face's level 0 and a write of each
// derived level before the sweep. After reset a clearing pass over all 96
// entries runs before start is taken. The single out_valid cycle carries the
// result; it cannot be held.
`default_nettype none
module texture_completeness_tracker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [2:0]  in_face,
  input  wire logic [3:0]  in_level,
  input  wire logic [15:0] in_pixel_format,
  input  wire logic [15:0] in_element_type,
  input  wire logic [14:0] in_size_x,
  input  wire logic [14:0] in_size_y,
  output logic             out_valid,
  output logic             out_is_npot,
  output logic             out_is_complete,
  output logic             out_use_black,
  output logic             out_found,
  output logic [15:0]      out_read_format,
  output logic [15:0]      out_read_type,
  output logic [14:0]      out_read_width,
  output logic [14:0]      out_read_height,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [4:0]  cfg_data
);
  localparam int AW = tct_pkg::ADDR_W;
  localparam int LW = tct_pkg::LVL_W;
  localparam int CW = tct_pkg::CNT_W;

  typedef enum logic [8:0] {
    ST_CLEAR = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_QRD   = 9'b000000100,
    ST_QOUT  = 9'b000001000,
    ST_GCHK  = 9'b000010000,
    ST_GWR   = 9'b000100000,
    ST_RBASE = 9'b001000000,
    ST_SCAN  = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_t;

  // memory: valid bit + descriptor
  logic [62:0] mem [tct_pkg::DEPTH];
  logic [62:0] rd_r;
  logic        we;
  logic [AW-1:0] addr;
  logic [62:0] wdata;

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rd_r <= mem[addr];
  end

  logic            rd_vld;
  tct_pkg::desc_t  rd_d;
  assign rd_vld = rd_r[62];
  assign rd_d   = tct_pkg::desc_t'(rd_r[61:0]);

  state_t state_r, state_nxt;
  logic [1:0] tgt_r;
  logic [4:0] lcnt_r;
  logic [2:0] minf_r;
  logic [1:0] wrs_r, wrt_r;
  logic npot_r, npot_nxt, cmpl_r, cmpl_nxt, blk_r, blk_nxt;

  logic [AW-1:0] clr_r, clr_nxt;
  logic [2:0] face_r, face_nxt;
  logic [LW-1:0] lvl_r, lvl_nxt;
  logic phase_r, phase_nxt;   // scan: 0 = address issued, 1 = data back
  tct_pkg::desc_t first_r, first_nxt, base_r, base_nxt;
  logic [14:0] ew_r, ew_nxt, eh_r, eh_nxt;
  logic [CW-1:0] lc_r, lc_nxt;
  logic gen_r, gen_nxt;      // set-path recheck vs generate
  logic [1:0] req_r;
  logic [2:0] qf_r;
  logic [LW-1:0] ql_r;
  logic qok_r;
  logic ovalid_nxt, found_nxt;
  tct_pkg::desc_t odat_nxt;
  logic found_r;
  tct_pkg::desc_t odat_r;

  logic [2:0] nf;
  logic [CW-1:0] nl;
  logic mip;
  always_comb begin
    nf = (tgt_r == tct_pkg::TGT_2D) ? 3'd1 :
         (tgt_r == tct_pkg::TGT_CUBE) ? 3'(tct_pkg::FACES) : 3'd0;
    if (lcnt_r == 5'd0) nl = CW'(1);
    else if (lcnt_r > 5'(tct_pkg::MAX_LEVELS)) nl = CW'(tct_pkg::MAX_LEVELS);
    else nl = CW'(lcnt_r);
    mip = (minf_r != tct_pkg::FILT_NEAREST) && (minf_r != tct_pkg::FILT_LINEAR);
  end

  function automatic logic [4:0] chain_len(input logic [14:0] w, input logic [14:0] h);
    logic [14:0] m;
    logic [4:0] c;
    m = (w > h) ? w : h;
    c = 5'd0;
    for (int i = 0; i < 15; i++) if (m[i]) c = 5'(i + 1);
    chain_len = c;
  endfunction

  function automatic logic is_npot(input logic [14:0] w, input logic [14:0] h);
    if (w == 15'd0 || h == 15'd0) is_npot = 1'b0;
    else is_npot = ((w & (w - 15'd1)) != 15'd0) || ((h & (h - 15'd1)) != 15'd0);
  endfunction

  logic [4:0] rd_lc;
  logic same_first;
  assign rd_lc = chain_len(rd_d.w, rd_d.h);
  assign same_first = (rd_d == first_r);

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r; face_nxt = face_r; lvl_nxt = lvl_r; phase_nxt = phase_r;
    first_nxt = first_r; base_nxt = base_r; ew_nxt = ew_r; eh_nxt = eh_r;
    lc_nxt = lc_r; gen_nxt = gen_r;
    npot_nxt = npot_r; cmpl_nxt = cmpl_r; blk_nxt = blk_r;
    ovalid_nxt = 1'b0; found_nxt = 1'b0; odat_nxt = '0;
    we = 1'b0; addr = '0; wdata = '0;
    unique case (state_r)
      ST_CLEAR: begin
        we = 1'b1; addr = clr_r;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(tct_pkg::DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          if (nf == 3'd0 || in_req_type == tct_pkg::REQ_RSVD) begin
            state_nxt = ST_DONE;
          end else if (in_req_type == tct_pkg::REQ_SET) begin
            if ((in_face < nf) && (CW'(in_level) < nl)) begin
              we = 1'b1;
              addr = tct_pkg::addr_of(in_face, in_level[LW-1:0]);
              wdata = {1'b1, in_pixel_format, in_element_type, in_size_x, in_size_y};
              gen_nxt = 1'b0;
              state_nxt = ST_RBASE; phase_nxt = 1'b0;
            end else state_nxt = ST_DONE;
          end else if (in_req_type == tct_pkg::REQ_GEN) begin
            if (npot_r) state_nxt = ST_DONE;
            else begin
              gen_nxt = 1'b1; state_nxt = ST_RBASE; phase_nxt = 1'b0;
            end
          end else begin
            addr = tct_pkg::addr_of(in_face, in_level[LW-1:0]);
            state_nxt = ST_QRD;
          end
        end
      end
      ST_QRD: begin
        // hold the query address so the data is still there next cycle
        addr = tct_pkg::addr_of(qf_r, ql_r);
        state_nxt = ST_QOUT;
      end
      ST_QOUT: begin
        ovalid_nxt = 1'b1;
        found_nxt = qok_r;
        odat_nxt = qok_r ? rd_d : '0;
        state_nxt = ST_IDLE;
      end
      ST_RBASE: begin
        // read face 0 level 0
        addr = '0;
        if (!phase_r) phase_nxt = 1'b1;
        else begin
          first_nxt = rd_d;
          face_nxt = '0; lvl_nxt = '0; phase_nxt = 1'b0;
          // generate keeps the flags until its base check has passed
          if (!gen_r) begin
            npot_nxt = 1'b0;
            cmpl_nxt = (chain_len(rd_d.w, rd_d.h) != 5'd0);
          end
          state_nxt = gen_r ? ST_GCHK : ST_SCAN;
        end
      end
      ST_GCHK: begin
        // all faces' level 0 valid and equal to face 0
        addr = tct_pkg::addr_of(face_r, '0);
        if (!phase_r) phase_nxt = 1'b1;
        else begin
          phase_nxt = 1'b0;
          if (!rd_vld || !same_first) begin
            npot_nxt = npot_r; cmpl_nxt = cmpl_r; state_nxt = ST_DONE;
          end else if (face_r + 3'd1 >= nf) begin
            face_nxt = '0; lvl_nxt = LW'(1);
            lc_nxt = CW'(chain_len(first_r.w, first_r.h));
            ew_nxt = tct_pkg::half_side(first_r.w);
            eh_nxt = tct_pkg::half_side(first_r.h);
            npot_nxt = npot_r; cmpl_nxt = cmpl_r;
            state_nxt = ST_GWR;
          end else face_nxt = face_r + 3'd1;
        end
      end
      ST_GWR: begin
        // faces equal, so every face uses face 0's base
        if (CW'(lvl_r) < lc_r && CW'(lvl_r) < nl && lvl_r != '0) begin
          we = 1'b1;
          addr = tct_pkg::addr_of(face_r, lvl_r);
          wdata = {1'b1, first_r.fmt, first_r.typ, ew_r, eh_r};
          ew_nxt = tct_pkg::half_side(ew_r);
          eh_nxt = tct_pkg::half_side(eh_r);
          lvl_nxt = lvl_r + LW'(1);
        end else if (face_r + 3'd1 < nf) begin
          face_nxt = face_r + 3'd1; lvl_nxt = LW'(1);
          ew_nxt = tct_pkg::half_side(first_r.w);
          eh_nxt = tct_pkg::half_side(first_r.h);
        end else begin
          gen_nxt = 1'b0; face_nxt = '0; lvl_nxt = '0; phase_nxt = 1'b0;
          npot_nxt = 1'b0;
          cmpl_nxt = (chain_len(first_r.w, first_r.h) != 5'd0);
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        addr = tct_pkg::addr_of(face_r, lvl_r);
        if (!phase_r) phase_nxt = 1'b1;
        else begin
          phase_nxt = 1'b0;
          if (lvl_r == '0) begin
            if (is_npot(rd_d.w, rd_d.h)) npot_nxt = 1'b1;
            if (!rd_vld || !same_first) cmpl_nxt = 1'b0;
            base_nxt = rd_d;
            lc_nxt = CW'(rd_lc);
            ew_nxt = tct_pkg::half_side(rd_d.w);
            eh_nxt = tct_pkg::half_side(rd_d.h);
          end else begin
            if (!rd_vld || rd_d.w != ew_r || rd_d.h != eh_r ||
                rd_d.fmt != base_r.fmt || rd_d.typ != base_r.typ) cmpl_nxt = 1'b0;
            ew_nxt = tct_pkg::half_side(ew_r);
            eh_nxt = tct_pkg::half_side(eh_r);
          end
          // next level of this face: only while chain still needs it
          if (lvl_r == '0 && CW'(1) < CW'(rd_lc) && CW'(1) >= nl) begin
            cmpl_nxt = 1'b0;
          end
          if ((lvl_r == '0 && CW'(1) < CW'(rd_lc) && CW'(1) < nl) ||
              (lvl_r != '0 && CW'(lvl_r) + CW'(1) < lc_r &&
               CW'(lvl_r) + CW'(1) < nl)) begin
            lvl_nxt = lvl_r + LW'(1);
          end else begin
            if (lvl_r != '0 && CW'(lvl_r) + CW'(1) < lc_r) cmpl_nxt = 1'b0;
            lvl_nxt = '0;
            if (face_r + 3'd1 < nf) face_nxt = face_r + 3'd1;
            else state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        ovalid_nxt = 1'b1;
        blk_nxt = (npot_r && (mip || wrs_r != tct_pkg::WRAP_CLAMP ||
                    wrt_r != tct_pkg::WRAP_CLAMP)) || (!cmpl_r && mip);
        if (!gen_r && req_r == tct_pkg::REQ_RSVD) blk_nxt = blk_r;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // recompute happened when the path reached ST_DONE through a scan
  logic recomputed_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR; clr_r <= '0;
      tgt_r <= '0; lcnt_r <= 5'd16; minf_r <= 3'd4; wrs_r <= '0; wrt_r <= '0;
      npot_r <= 1'b0; cmpl_r <= 1'b0; blk_r <= 1'b0;
      out_valid <= 1'b0; recomputed_r <= 1'b0;
      face_r <= '0; lvl_r <= '0; phase_r <= 1'b0; gen_r <= 1'b0; req_r <= '0;
    end else begin
      state_r <= state_nxt; clr_r <= clr_nxt;
      face_r <= face_nxt; lvl_r <= lvl_nxt; phase_r <= phase_nxt; gen_r <= gen_nxt;
      npot_r <= npot_nxt; cmpl_r <= cmpl_nxt;
      if (state_r == ST_DONE && recomputed_r) blk_r <= blk_nxt;
      if (state_r == ST_SCAN) recomputed_r <= 1'b1;
      else if (state_r == ST_IDLE) recomputed_r <= 1'b0;
      out_valid <= ovalid_nxt;
      if (state_r == ST_IDLE && start) req_r <= in_req_type;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          tct_pkg::CFG_TARGET: tgt_r <= cfg_data[1:0];
          tct_pkg::CFG_LEVELS: lcnt_r <= cfg_data;
          tct_pkg::CFG_MINF:   minf_r <= cfg_data[2:0];
          tct_pkg::CFG_WRAPS:  wrs_r <= cfg_data[1:0];
          tct_pkg::CFG_WRAPT:  wrt_r <= cfg_data[1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    first_r <= first_nxt; base_r <= base_nxt; ew_r <= ew_nxt; eh_r <= eh_nxt;
    lc_r <= lc_nxt; found_r <= found_nxt; odat_r <= odat_nxt;
    if (state_r == ST_IDLE && start) begin
      qf_r <= in_face; ql_r <= in_level[LW-1:0];
      qok_r <= (in_face < nf) && (CW'(in_level) < nl);
    end
  end

  assign busy = (state_r != ST_IDLE);
  assign cfg_ready = rst_n;
  assign out_is_npot = npot_r;
  assign out_is_complete = cmpl_r;
  assign out_use_black = blk_r;
  assign out_found = found_r;
  assign out_read_format = odat_r.fmt;
  assign out_read_type = odat_r.typ;
  assign out_read_width = odat_r.w;
  assign out_read_height = odat_r.h;
endmodule
`default_nettype wire

### hw/rtl/tct_checker.sv
// ----------------------------------------------------------------------------
// tct_checker
// Port-level checks for the texture completeness tracker.
// ----------------------------------------------------------------------------
`default_nettype none
module tct_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid,
  input wire logic out_found,
  input wire logic out_use_black,
  input wire logic [15:0] out_read_format
);
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accept did not raise busy");
  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_found_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_read_format == 16'd0))
    else $error("not-found result carries data");
  a_black_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && !out_valid && $past(!busy)) |-> $stable(out_use_black))
    else $error("flag moved while idle");
endmodule

bind texture_completeness_tracker tct_checker u_tct_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_found(out_found), .out_use_black(out_use_black),
  .out_read_format(out_read_format)
);
`default_nettype wire
